// ===== hdl/sc2a_pkg.sv =====
`default_nettype none

package sc2a_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 7;
  localparam int unsigned CharW = 7;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [CharW-1:0] char_t;

  localparam key_t KeyNone   = 7'd0;
  localparam key_t KeyLctrl  = 7'd29;
  localparam key_t KeyLshift = 7'd42;
  localparam key_t KeyRshift = 7'd54;
  localparam key_t KeyCaps   = 7'd58;
  localparam key_t KeyRows   = 7'd90;

  // Unshifted character for a key; zero where the key has no mapping
  // (this also covers every key past the end of the table).
  function automatic char_t plain_char(input key_t key);
    char_t c;
    case (key)
      7'd1:    c = 7'h1B;
      7'd2:    c = 7'h31;
      7'd3:    c = 7'h32;
      7'd4:    c = 7'h33;
      7'd5:    c = 7'h34;
      7'd6:    c = 7'h35;
      7'd7:    c = 7'h36;
      7'd8:    c = 7'h37;
      7'd9:    c = 7'h38;
      7'd10:   c = 7'h39;
      7'd11:   c = 7'h30;
      7'd12:   c = 7'h2D;
      7'd13:   c = 7'h3D;
      7'd14:   c = 7'h08;
      7'd15:   c = 7'h09;
      7'd16:   c = 7'h71;
      7'd17:   c = 7'h77;
      7'd18:   c = 7'h65;
      7'd19:   c = 7'h72;
      7'd20:   c = 7'h74;
      7'd21:   c = 7'h79;
      7'd22:   c = 7'h75;
      7'd23:   c = 7'h69;
      7'd24:   c = 7'h6F;
      7'd25:   c = 7'h70;
      7'd26:   c = 7'h5B;
      7'd27:   c = 7'h5D;
      7'd28:   c = 7'h0A;
      7'd30:   c = 7'h61;
      7'd31:   c = 7'h73;
      7'd32:   c = 7'h64;
      7'd33:   c = 7'h66;
      7'd34:   c = 7'h67;
      7'd35:   c = 7'h68;
      7'd36:   c = 7'h6A;
      7'd37:   c = 7'h6B;
      7'd38:   c = 7'h6C;
      7'd39:   c = 7'h3B;
      7'd40:   c = 7'h27;
      7'd41:   c = 7'h60;
      7'd43:   c = 7'h5C;
      7'd44:   c = 7'h7A;
      7'd45:   c = 7'h78;
      7'd46:   c = 7'h63;
      7'd47:   c = 7'h76;
      7'd48:   c = 7'h62;
      7'd49:   c = 7'h6E;
      7'd50:   c = 7'h6D;
      7'd51:   c = 7'h2C;
      7'd52:   c = 7'h2E;
      7'd53:   c = 7'h2F;
      7'd55:   c = 7'h2A;
      7'd57:   c = 7'h20;
      7'd74:   c = 7'h2D;
      7'd78:   c = 7'h2B;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // Shifted character; zero means fall back to the plain column.
  function automatic char_t shift_char(input key_t key);
    char_t c;
    case (key)
      7'd2:    c = 7'h21;
      7'd3:    c = 7'h40;
      7'd4:    c = 7'h23;
      7'd5:    c = 7'h24;
      7'd6:    c = 7'h25;
      7'd7:    c = 7'h5E;
      7'd8:    c = 7'h26;
      7'd9:    c = 7'h2A;
      7'd10:   c = 7'h28;
      7'd11:   c = 7'h29;
      7'd12:   c = 7'h5F;
      7'd13:   c = 7'h2B;
      7'd16:   c = 7'h51;
      7'd17:   c = 7'h57;
      7'd18:   c = 7'h45;
      7'd19:   c = 7'h52;
      7'd20:   c = 7'h54;
      7'd21:   c = 7'h59;
      7'd22:   c = 7'h55;
      7'd23:   c = 7'h49;
      7'd24:   c = 7'h4F;
      7'd25:   c = 7'h50;
      7'd26:   c = 7'h7B;
      7'd27:   c = 7'h7D;
      7'd30:   c = 7'h41;
      7'd31:   c = 7'h53;
      7'd32:   c = 7'h44;
      7'd33:   c = 7'h46;
      7'd34:   c = 7'h47;
      7'd35:   c = 7'h48;
      7'd36:   c = 7'h4A;
      7'd37:   c = 7'h4B;
      7'd38:   c = 7'h4C;
      7'd39:   c = 7'h3A;
      7'd40:   c = 7'h22;
      7'd41:   c = 7'h7E;
      7'd43:   c = 7'h7C;
      7'd44:   c = 7'h5A;
      7'd45:   c = 7'h58;
      7'd46:   c = 7'h43;
      7'd47:   c = 7'h56;
      7'd48:   c = 7'h42;
      7'd49:   c = 7'h4E;
      7'd50:   c = 7'h4D;
      7'd51:   c = 7'h3C;
      7'd52:   c = 7'h3E;
      7'd53:   c = 7'h3F;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/scancode_to_ascii_decoder.sv =====
// Channel | Dir | Handshake         | Payload
// in_     | in  | in_tvalid/tready  | in_tdata[7:0]  = scan_byte
// out_    | out | out_tvalid/tready | out_tdata[7:0] = character (6:0), zero pad (7)
//
// One beat per cycle while the result is not stalled; bytes pass the input
// register, then the result register fed by table lookup and shift/caps update.
// Presses, modifier keys, key zero and left ctrl produce no result beat.
// rst_n is synchronous, active low; it clears both valids and both flags.
// A stalled result only blocks the input stage if that stage holds a byte
// that would produce a result; other bytes keep draining.
`default_nettype none

module scancode_to_ascii_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] scan_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [6:0] character, [7] zero
);

  logic                        s1_vld_r;
  logic [sc2a_pkg::ByteW-1:0]  s1_byte_r;
  logic                        shift_r, shift_nxt;
  logic                        caps_r, caps_nxt;
  logic                        out_vld_r, out_vld_nxt;
  sc2a_pkg::char_t             out_char_r;

  logic            released;
  sc2a_pkg::key_t  key;
  logic            is_shift, is_caps, silent;
  logic            emit;
  logic            out_free;
  logic            s1_adv;
  sc2a_pkg::char_t plain_c, shift_c, ch;

  assign released = s1_byte_r[7];
  assign key      = s1_byte_r[6:0];
  assign is_shift = (key == sc2a_pkg::KeyLshift) || (key == sc2a_pkg::KeyRshift);
  assign is_caps  = (key == sc2a_pkg::KeyCaps);
  assign silent   = (key == sc2a_pkg::KeyNone) || (key == sc2a_pkg::KeyLctrl) ||
                    is_shift || is_caps;
  assign emit     = s1_vld_r && released && !silent;

  assign plain_c  = sc2a_pkg::plain_char(key);
  assign shift_c  = sc2a_pkg::shift_char(key);
  assign ch       = ((shift_r || caps_r) && (shift_c != '0)) ? shift_c : plain_c;

  assign out_free  = !out_vld_r || out_tready;
  assign s1_adv    = s1_vld_r && (!emit || out_free);
  assign in_tready = !s1_vld_r || s1_adv;

  always_comb begin
    shift_nxt   = shift_r;
    caps_nxt    = caps_r;
    out_vld_nxt = out_vld_r && !out_tready;
    if (s1_adv) begin
      if (is_shift) begin
        shift_nxt = !released;
      end
      if (is_caps && released) begin
        caps_nxt = !caps_r;
      end
      if (emit) begin
        out_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      shift_r   <= 1'b0;
      caps_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_vld_r <= in_tvalid;
      end
      shift_r   <= shift_nxt;
      caps_r    <= caps_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
    if (s1_adv && emit) begin
      out_char_r <= ch;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_char_r};

`ifndef SYNTHESIS
  a_shift_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && is_shift |=> shift_r == !$past(released))
    else $error("shift flag not updated by shift key");

  a_caps_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && is_caps && released |=> caps_r != $past(caps_r))
    else $error("caps flag not toggled on caps release");

  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit |=> out_tvalid && out_tdata[6:0] == $past(ch))
    else $error("result beat lost or corrupted");

  a_beyond_table: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit && key >= sc2a_pkg::KeyRows |=> out_tdata[6:0] == '0)
    else $error("key beyond table gave nonzero character");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(s1_adv && emit))
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ===== verif/scancode_to_ascii_decoder_tb.sv =====
`timescale 1ns / 100ps

module scancode_to_ascii_decoder_tb;

  localparam int PHASE_ITEMS = 382;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 2000;
  localparam int MAX_PRINTS  = 20;

  typedef struct packed {
    logic [7:0]      scan;
    logic            fixed;   // want is typed in, not predicted
    sc2a_pkg::char_t want;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  // Character table, plain column
  sc2a_pkg::char_t plain_col [0:89] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Shifted column; zero falls back to plain
  sc2a_pkg::char_t shift_col [0:89] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  dir_row_t dir_rows [25] = '{
    '{8'h00, 1'b0, 7'h00},   // key zero press
    '{8'h80, 1'b0, 7'h00},   // key zero release
    '{8'h9E, 1'b1, 7'h61},   // 'a' right after reset
    '{8'hFF, 1'b1, 7'h00},   // top key, past the table
    '{8'hDA, 1'b1, 7'h00},   // first key past the table
    '{8'h7F, 1'b0, 7'h00},
    '{8'h1D, 1'b0, 7'h00},   // left ctrl press/release: ignored
    '{8'h9D, 1'b0, 7'h00},
    '{8'hC4, 1'b1, 7'h00},   // in table, no mapping
    '{8'h81, 1'b1, 7'h1B},   // escape
    '{8'h2A, 1'b0, 7'h00},   // left shift down
    '{8'h9E, 1'b0, 7'h00},
    '{8'h82, 1'b0, 7'h00},
    '{8'h8E, 1'b1, 7'h08},   // backspace ignores shift
    '{8'hAA, 1'b0, 7'h00},
    '{8'h36, 1'b0, 7'h00},   // right shift down
    '{8'h9C, 1'b1, 7'h0A},   // enter
    '{8'hCA, 1'b0, 7'h00},   // keypad minus, no shifted entry
    '{8'hB6, 1'b0, 7'h00},
    '{8'h3A, 1'b0, 7'h00},   // caps press: no toggle
    '{8'hBA, 1'b0, 7'h00},   // caps release: on
    '{8'h90, 1'b0, 7'h00},
    '{8'h8F, 1'b1, 7'h09},   // tab
    '{8'hCE, 1'b0, 7'h00},
    '{8'hBA, 1'b0, 7'h00}    // caps off
  };

  sc2a_pkg::char_t char_q [$];
  bit              kb_shift, kb_caps;
  int              errors, n_in, n_out, n_upper, stall_cycles, idle_cnt;
  int              send_pct, stall_pct;
  bit              hold_go, hold_rx;
  bit              pend_valid;
  sc2a_pkg::key_t  pend_key;

  scancode_to_ascii_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_err(input string what);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  // Tracks shift/caps and returns 1 when the byte yields a character
  function automatic bit decode_scan(input logic [7:0] b, output sc2a_pkg::char_t ch);
    sc2a_pkg::key_t key;
    bit             rel;
    key = b[6:0];
    rel = b[7];
    ch  = '0;
    if (key == sc2a_pkg::KeyNone || key == sc2a_pkg::KeyLctrl) return 1'b0;
    if (key == sc2a_pkg::KeyLshift || key == sc2a_pkg::KeyRshift) begin
      kb_shift = !rel;
      return 1'b0;
    end
    if (key == sc2a_pkg::KeyCaps) begin
      if (rel) kb_caps = !kb_caps;
      return 1'b0;
    end
    if (!rel) return 1'b0;
    if (key >= sc2a_pkg::KeyRows) begin
      ch = '0;
    end else if ((kb_shift || kb_caps) && shift_col[key] != '0) begin
      ch = shift_col[key];
      n_upper++;
    end else begin
      ch = plain_col[key];
    end
    return 1'b1;
  endfunction

  // Mostly typing: press/release pairs, plus modifiers and some noise
  function automatic logic [7:0] pick_scan();
    int             r;
    sc2a_pkg::key_t k;
    r = $urandom_range(0, 99);
    if (pend_valid && $urandom_range(0, 3) != 0) begin
      pend_valid = 1'b0;
      return {1'b1, pend_key};
    end
    if (r < 8) return {$urandom_range(0, 1) == 1,
                       ($urandom_range(0, 1) ? sc2a_pkg::KeyLshift : sc2a_pkg::KeyRshift)};
    if (r < 14) return {$urandom_range(0, 1) == 1, sc2a_pkg::KeyCaps};
    if (r < 20) return 8'($urandom_range(0, 255));
    if (r < 26) return {1'b1, 7'($urandom_range(90, 127))};
    k = 7'($urandom_range(1, 89));
    if ($urandom_range(0, 1) && !pend_valid) begin
      pend_valid = 1'b1;
      pend_key   = k;
      return {1'b0, k};
    end
    return {1'b1, k};
  endfunction

  // Offers one beat and returns at the edge that accepts it
  task automatic send_beat(input logic [7:0] b, input bit fixed,
                           input sc2a_pkg::char_t want);
    int              gap;
    sc2a_pkg::char_t ch;
    bit              hit;
    gap = 0;
    while (send_pct > 0 && $urandom_range(0, 99) < send_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_in++;
    hit = decode_scan(b, ch);
    if (fixed) char_q.push_back(want);
    else if (hit) char_q.push_back(ch);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (char_q.size() != 0) @(posedge clk);
  endtask

  // Long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= !hold_rx && ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (char_q.size() == 0) begin
        report_err($sformatf("unexpected result beat 0x%02h", out_tdata));
      end else begin
        sc2a_pkg::char_t exp_ch;
        exp_ch = char_q.pop_front();
        n_out++;
        if (out_tdata !== {1'b0, exp_ch})
          report_err($sformatf("character 0x%02h, expected 0x%02h", out_tdata, exp_ch));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_tready && hold_rx) stall_cycles++;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("ERROR: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, char_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int send_tab [4];
    int stall_tab [4];
    send_tab  = '{0, 77, 0, 18};
    stall_tab = '{0, 0, 77, 18};
    send_pct  = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].scan, dir_rows[i].fixed, dir_rows[i].want);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_pct  = send_tab[ph];
      stall_pct = stall_tab[ph];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == 100) hold_go = 1'b1;
        send_beat(pick_scan(), 1'b0, '0);
      end
      drain_results();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d scan bytes, checked %0d characters (%0d from the shifted column)",
             n_in, n_out, n_upper);
    $display("Four pacing phases; input held back %0d cycles during the long output stall",
             stall_cycles);
    if (errors == 0 && char_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sc2a_pkg.sv
hdl/scancode_to_ascii_decoder.sv
verif/scancode_to_ascii_decoder_tb.sv
